[rtl/arsc_pkg.sv]
package arsc_pkg;

	// Field widths
	localparam int SIZE_W  = 21;
	localparam int RUN_W   = 16;
	localparam int STAMP_W = 48;
	localparam int TOTAL_W = 64;

	// Size and run limits
	localparam logic [SIZE_W-1:0] SIZE_CAP = 21'd1048576;
	localparam logic [RUN_W-1:0]  RUN_CAP  = 16'hFFFF;

	// Register reset values
	localparam logic [SIZE_W-1:0] MIN_RESET    = 21'd1024;
	localparam logic [SIZE_W-1:0] MAX_RESET    = 21'd65536;
	localparam logic [RUN_W-1:0]  GROW_RESET   = 16'd3;
	localparam logic [RUN_W-1:0]  SHRINK_RESET = 16'd4;

	// floor(x / 10) for x below 2^22 as (x * TENTH_MUL) >> TENTH_SHIFT
	localparam int                TENTH_MUL_W = 20;
	localparam logic [TENTH_MUL_W-1:0] TENTH_MUL = 20'd838861;
	localparam int                TENTH_SHIFT = 23;
	localparam int                TENTH_W     = SIZE_W + TENTH_MUL_W;

	// Quotient bits resolved per divider cycle
	localparam int DIV_BITS = 4;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_MIN_SIZE         = 2'd0;
	localparam cfg_idx_t REG_MAX_SIZE         = 2'd1;
	localparam cfg_idx_t REG_GROW_THRESHOLD   = 2'd2;
	localparam cfg_idx_t REG_SHRINK_THRESHOLD = 2'd3;

	// Request commands
	localparam logic CMD_OBSERVE = 1'b0;
	localparam logic CMD_RESET   = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [SIZE_W-1:0]  read_bytes;
		logic [STAMP_W-1:0] now_ms;
	} arsc_obs_t;

	typedef struct packed {
		logic [SIZE_W-1:0]  next_size;
		logic [SIZE_W-1:0]  average_read;
		logic [TOTAL_W-1:0] read_total;
		logic [TOTAL_W-1:0] byte_total;
		logic [RUN_W-1:0]   full_run;
		logic [RUN_W-1:0]   short_run;
		logic [STAMP_W-1:0] last_stamp;
	} arsc_res_t;

endpackage

[rtl/adaptive_read_size_controller.sv]
// Adaptive read size controller.
// Requests arrive on obs_valid/obs_ready/obs_data: cmd 0 reports one read
// (read_bytes, now_ms), cmd 1 puts the recommended size back to the minimum.
// Each request yields one result on res_valid/res_ready/res_data with the
// next recommended size, the average of the last HISTORY_DEPTH reads, the
// lifetime totals, both run counters and the last timestamp.
// Registers are written on cfg_valid/cfg_ready/cfg_index/cfg_data; the user
// must write them only while idle, which the block itself does not enforce. cfg_ready is always high.
// Timing: one request at a time. A request passes the tenth, update, divide
// and done states from acceptance to the result register; the divide state
// is an iterative divider for the average, 4 quotient bits per cycle over
// the window sum of SW = 21 + clog2(HISTORY_DEPTH) bits, and no new request
// is taken until the previous one has reached the result register.
// The history ring lives in a one-port-read synchronous memory; it is read
// when a request is taken and written back in the update cycle.
// A finished result waits in the output register; a new request is taken as
// soon as the previous one has reached it, and the next result waits until
// the stalled one is taken.
// Reset: registers return to their reset values, size to 1024, counters,
// totals and history fill to zero. The history memory needs no clearing.
module adaptive_read_size_controller #(
	parameter int HISTORY_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        obs_valid,
	output logic                        obs_ready,
	input  arsc_pkg::arsc_obs_t         obs_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output arsc_pkg::arsc_res_t         res_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  arsc_pkg::cfg_idx_t          cfg_index,
	input  logic [arsc_pkg::SIZE_W-1:0] cfg_data
);
	import arsc_pkg::*;

	localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int VALID_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W   = SIZE_W + $clog2(HISTORY_DEPTH);
	localparam int DIV_CYC = (SUM_W + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_W   = DIV_CYC * DIV_BITS;
	localparam int CNT_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TENTH,
		ST_UPDATE,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	state_t              state_q;

	// Configuration registers
	logic [SIZE_W-1:0]   min_q;
	logic [SIZE_W-1:0]   max_q;
	logic [RUN_W-1:0]    grow_q;
	logic [RUN_W-1:0]    shrink_q;

	// Controller state
	logic [SIZE_W-1:0]   cur_q;
	logic [RUN_W-1:0]    full_q;
	logic [RUN_W-1:0]    short_q;
	logic [VALID_W-1:0]  valid_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SUM_W-1:0]    sum_q;
	logic [TOTAL_W-1:0]  reads_q;
	logic [TOTAL_W-1:0]  bytes_q;
	logic [STAMP_W-1:0]  stamp_q;

	// History ring
	logic [SIZE_W-1:0]   hist_mem [HISTORY_DEPTH];
	logic [SIZE_W-1:0]   hist_rd_q;

	// Request pipeline
	logic                cmd_s1;
	logic [SIZE_W-1:0]   bytes_s1;
	logic [STAMP_W-1:0]  stamp_s1;
	logic [SIZE_W-1:0]   tenth_s2;

	// Divider
	logic [DIV_W-1:0]    div_num_q;
	logic [VALID_W-1:0]  div_rem_q;
	logic [VALID_W-1:0]  div_den_q;
	logic [CNT_W-1:0]    div_cnt_q;

	logic                res_valid_q;
	arsc_res_t           res_q;

	logic                obs_take;
	logic [SIZE_W-1:0]   min_cap;
	logic [SIZE_W-1:0]   max_cap;
	logic [SIZE_W-1:0]   eff_min;
	logic [SIZE_W-1:0]   eff_max;
	logic [SIZE_W-1:0]   bytes_sat;
	logic [TENTH_W-1:0]  tenth_prod;

	logic [SIZE_W-1:0]   cut;
	logic                is_full;
	logic [RUN_W-1:0]    full_inc;
	logic [RUN_W-1:0]    short_inc;
	logic [SIZE_W:0]     grown;
	logic [SIZE_W-1:0]   shrunk;
	logic                hist_full;
	logic [SUM_W-1:0]    sum_drop;
	logic [SIZE_W-1:0]   nxt_cur;
	logic [RUN_W-1:0]    nxt_full;
	logic [RUN_W-1:0]    nxt_short;
	logic [SUM_W-1:0]    nxt_sum;
	logic [VALID_W-1:0]  nxt_valid;
	logic [SLOT_W-1:0]   nxt_slot;

	logic [VALID_W:0]    rem_sh;
	logic [VALID_W-1:0]  rem_w;
	logic [DIV_W-1:0]    num_w;

	assign obs_ready = (state_q == ST_IDLE);
	assign obs_take  = obs_valid && obs_ready;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Clamp bounds: cap wide values, lift a zero minimum, raise an inverted maximum
	always_comb begin
		min_cap   = (min_q > SIZE_CAP) ? SIZE_CAP : min_q;
		eff_min   = (min_cap == '0) ? SIZE_W'(1) : min_cap;
		max_cap   = (max_q > SIZE_CAP) ? SIZE_CAP : max_q;
		eff_max   = (max_cap < eff_min) ? eff_min : max_cap;
		bytes_sat = (obs_data.read_bytes > SIZE_CAP) ? SIZE_CAP : obs_data.read_bytes;
	end

	// Tenth of the current size by reciprocal multiply
	assign tenth_prod = TENTH_W'(cur_q) * TENTH_W'(TENTH_MUL);

	// Work out the new size, runs and window for the request in hand
	always_comb begin
		cut       = cur_q - tenth_s2;
		is_full   = (bytes_s1 >= cut);
		full_inc  = (full_q == RUN_CAP) ? full_q : full_q + 1'b1;
		short_inc = (short_q == RUN_CAP) ? short_q : short_q + 1'b1;
		grown     = {cur_q, 1'b0};
		shrunk    = cur_q >> 1;
		hist_full = (valid_q == VALID_W'(HISTORY_DEPTH));
		sum_drop  = hist_full ? SUM_W'(hist_rd_q) : '0;

		nxt_cur   = cur_q;
		nxt_full  = full_q;
		nxt_short = short_q;
		nxt_sum   = sum_q;
		nxt_valid = valid_q;
		nxt_slot  = slot_q;

		if (cmd_s1 == CMD_RESET) begin
			nxt_cur   = eff_min;
			nxt_full  = '0;
			nxt_short = '0;
		end else begin
			nxt_sum   = sum_q - sum_drop + SUM_W'(bytes_s1);
			nxt_valid = hist_full ? valid_q : valid_q + 1'b1;
			nxt_slot  = (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			if (is_full) begin
				nxt_short = '0;
				nxt_full  = full_inc;
				if (full_inc >= grow_q && cur_q < eff_max) begin
					nxt_cur  = (grown > {1'b0, eff_max}) ? eff_max : grown[SIZE_W-1:0];
					nxt_full = '0;
				end
			end else begin
				nxt_full  = '0;
				nxt_short = short_inc;
				if (short_inc >= shrink_q && cur_q > eff_min) begin
					nxt_cur   = (shrunk < eff_min) ? eff_min : shrunk;
					nxt_short = '0;
				end
			end
		end
	end

	// Restoring division, DIV_BITS quotient bits per cycle
	always_comb begin
		rem_w  = div_rem_q;
		num_w  = div_num_q;
		rem_sh = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			rem_sh = {rem_w, num_w[DIV_W-1]};
			num_w  = {num_w[DIV_W-2:0], 1'b0};
			if (rem_sh >= {1'b0, div_den_q}) begin
				rem_sh   = rem_sh - {1'b0, div_den_q};
				num_w[0] = 1'b1;
			end
			rem_w = rem_sh[VALID_W-1:0];
		end
	end

	// History memory: read the oldest entry on accept, write the new read on update.
	// One request at a time, so the read and write never overlap on an entry.
	always_ff @(posedge clk) begin
		if (obs_take) begin
			hist_rd_q <= hist_mem[slot_q];
		end
		if (state_q == ST_UPDATE && cmd_s1 == CMD_OBSERVE) begin
			hist_mem[slot_q] <= bytes_s1;
		end
	end

	// Sequencer, state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			min_q       <= MIN_RESET;
			max_q       <= MAX_RESET;
			grow_q      <= GROW_RESET;
			shrink_q    <= SHRINK_RESET;
			cur_q       <= MIN_RESET;
			full_q      <= '0;
			short_q     <= '0;
			valid_q     <= '0;
			slot_q      <= '0;
			sum_q       <= '0;
			reads_q     <= '0;
			bytes_q     <= '0;
			stamp_q     <= '0;
			cmd_s1      <= CMD_OBSERVE;
			bytes_s1    <= '0;
			stamp_s1    <= '0;
			tenth_s2    <= '0;
			div_num_q   <= '0;
			div_rem_q   <= '0;
			div_den_q   <= '0;
			div_cnt_q   <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// Register writes
			if (cfg_valid) begin
				case (cfg_index)
					REG_MIN_SIZE:         min_q    <= cfg_data;
					REG_MAX_SIZE:         max_q    <= cfg_data;
					REG_GROW_THRESHOLD:   grow_q   <= cfg_data[RUN_W-1:0];
					REG_SHRINK_THRESHOLD: shrink_q <= cfg_data[RUN_W-1:0];
					default: ;
				endcase
			end

			// Drop the result once taken, unless the next one replaces it
			if (res_valid_q && res_ready && state_q != ST_DONE) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (obs_take) begin
						cmd_s1   <= obs_data.cmd;
						bytes_s1 <= bytes_sat;
						stamp_s1 <= obs_data.now_ms;
						state_q  <= ST_TENTH;
					end
				end
				ST_TENTH: begin
					tenth_s2 <= SIZE_W'(tenth_prod >> TENTH_SHIFT);
					state_q  <= ST_UPDATE;
				end
				ST_UPDATE: begin
					cur_q   <= nxt_cur;
					full_q  <= nxt_full;
					short_q <= nxt_short;
					sum_q   <= nxt_sum;
					valid_q <= nxt_valid;
					slot_q  <= nxt_slot;
					if (cmd_s1 == CMD_OBSERVE) begin
						reads_q <= reads_q + 1'b1;
						bytes_q <= bytes_q + TOTAL_W'(bytes_s1);
						stamp_q <= stamp_s1;
					end
					div_num_q <= DIV_W'(nxt_sum);
					div_rem_q <= '0;
					div_den_q <= nxt_valid;
					div_cnt_q <= '0;
					state_q   <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					div_num_q <= num_w;
					div_rem_q <= rem_w;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == CNT_W'(DIV_CYC - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold until the output register is free
					if (!res_valid_q || res_ready) begin
						res_valid_q        <= 1'b1;
						res_q.next_size    <= cur_q;
						res_q.average_read <= (div_den_q == '0) ? '0
							: div_num_q[SIZE_W-1:0];
						res_q.read_total   <= reads_q;
						res_q.byte_total   <= bytes_q;
						res_q.full_run     <= full_q;
						res_q.short_run    <= short_q;
						res_q.last_stamp   <= stamp_q;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Recommended size stays between one byte and the size cap
	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q != '0 && cur_q <= SIZE_CAP)
		else $error("recommended size out of range");

	// History fill never passes the ring depth
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q <= VALID_W'(HISTORY_DEPTH))
		else $error("history fill beyond depth");

	// An observed read bumps the read total by exactly one
	a_read_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && cmd_s1 == CMD_OBSERVE)
		|=> reads_q == $past(reads_q) + 1'b1)
		else $error("read total not advanced");

	// No second request is taken while one is in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		obs_take |=> !obs_ready)
		else $error("request taken while busy");

endmodule
